@@ sv/sbpf_pkg.sv @@
`default_nettype none

package sbpf_pkg;

   localparam int JOB_DEPTH = 4;
   localparam int JOB_PTR_W = $clog2(JOB_DEPTH);
   localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);

   localparam logic [7:0] HEADER_RESET = 8'hFF;
   localparam logic [7:0] ERROR_BYTE   = 8'h00;

   localparam logic OP_START = 1'b0;
   localparam logic OP_DATA  = 1'b1;

   typedef struct packed {
      logic       operation;
      logic [7:0] servo_id;
      logic [7:0] payload_count;
      logic [7:0] command_code;
      logic [7:0] payload_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_end;
      logic       packet_end;
      logic       error;
   } rsp_type;

   typedef enum logic [1:0] {
      JOB_START,
      JOB_DATA,
      JOB_ERROR
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic [7:0]   id_byte;
      logic [7:0]   cnt_byte;
      logic [7:0]   cmd_dat_byte;
      logic [7:0]   chk_byte;
      logic         with_chk;
   } job_type;

   typedef enum logic [2:0] {
      SEQ_FIRST,
      SEQ_HDR1,
      SEQ_ID,
      SEQ_CNT,
      SEQ_CMD,
      SEQ_CHK
   } seq_type;

endpackage

`default_nettype wire

@@ sv/sbpf_req_if.sv @@
`default_nettype none

interface sbpf_req_if;
   import sbpf_pkg::*;

   logic    valid;
   logic    ready;
   req_type data;

   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

@@ sv/sbpf_rsp_if.sv @@
`default_nettype none

interface sbpf_rsp_if;
   import sbpf_pkg::*;

   logic    valid;
   logic    ready;
   rsp_type data;

   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

@@ sv/servo_bus_packet_framer.sv @@
// Servo-bus packet framer.
// req_ch takes one transfer per item: a start item (operation 0) with servo id,
// payload count and command code, or a data item (operation 1) with one payload byte.
// rsp_ch gives one transfer per serialized byte. A start item yields the header
// byte twice, id, count and command, plus the checksum when the count is zero.
// A data item yields its byte, plus the checksum after the last counted byte.
// A data item with no open packet yields one error transfer with byte zero.
// csr_wr_en / csr_wr_data set the header byte; write only while idle.
// An item's first byte passes through the job queue and then the output register
// before it is valid on rsp_ch.
// Throughput: the output side moves one byte per cycle while rsp_ch does not stall;
// an item yields 1 to 6 bytes from the byte sequencer. A four-entry
// job queue lets req_ch take an item per cycle, while it is not full, as the sequencer drains.
// When rsp_ch stalls, the output register holds, the queue fills, and
// req_ch.ready drops once four items wait.
// Reset clears the queue, the packet state and sets the header byte to 0xFF.
`default_nettype none

module servo_bus_packet_framer (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data,
   sbpf_req_if.sink   req_ch,
   sbpf_rsp_if.source rsp_ch
);
   import sbpf_pkg::*;

   logic [7:0] header_ff;
   logic [7:0] header_in;
   job_type    push_job;
   job_type    head_job;
   logic       job_push;
   logic       job_full;
   logic       job_pop;
   logic       job_empty;

   assign header_in = csr_wr_en ? csr_wr_data : header_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= HEADER_RESET;
      end else begin
         header_ff <= header_in;
      end
   end

   sbpf_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_ch),
      .job      (push_job),
      .job_push (job_push),
      .job_full (job_full)
   );

   sbpf_job_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (push_job),
      .full     (job_full),
      .pop      (job_pop),
      .head_job (head_job),
      .empty    (job_empty)
   );

   sbpf_back u_back (
      .clock        (clock),
      .reset        (reset),
      .header_value (header_ff),
      .head_job     (head_job),
      .job_empty    (job_empty),
      .job_pop      (job_pop),
      .rsp          (rsp_ch)
   );

endmodule

`default_nettype wire

@@ sv/sbpf_job_fifo.sv @@
`default_nettype none

module sbpf_job_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  sbpf_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output sbpf_pkg::job_type head_job,
   output logic             empty
);
   import sbpf_pkg::*;

   job_type                mem_ff [JOB_DEPTH];
   logic [JOB_PTR_W-1:0]   wr_ptr_ff;
   logic [JOB_PTR_W-1:0]   wr_ptr_in;
   logic [JOB_PTR_W-1:0]   rd_ptr_ff;
   logic [JOB_PTR_W-1:0]   rd_ptr_in;
   logic [JOB_CNT_W-1:0]   count_ff;
   logic [JOB_CNT_W-1:0]   count_in;
   logic                   do_push;
   logic                   do_pop;

   assign full     = (count_ff == JOB_CNT_W'(JOB_DEPTH));
   assign empty    = (count_ff == '0);
   assign head_job = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + JOB_PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + JOB_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + JOB_CNT_W'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - JOB_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= JOB_CNT_W'(JOB_DEPTH))
      else $error("job queue count beyond depth");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff - rd_ptr_ff) == count_ff[JOB_PTR_W-1:0])
      else $error("job queue pointers disagree with count");

endmodule

`default_nettype wire

@@ sv/sbpf_front.sv @@
`default_nettype none

module sbpf_front (
   input  logic              clock,
   input  logic              reset,
   sbpf_req_if.sink          req,
   output sbpf_pkg::job_type job,
   output logic              job_push,
   input  logic              job_full
);
   import sbpf_pkg::*;

   logic       packet_open_ff;
   logic       packet_open_in;
   logic [7:0] bytes_left_ff;
   logic [7:0] bytes_left_in;
   logic [7:0] running_sum_ff;
   logic [7:0] running_sum_in;
   logic [7:0] start_sum;
   logic [7:0] data_sum;
   logic       accept;

   assign req.ready = !job_full;
   assign accept    = req.valid && req.ready;
   assign job_push  = accept;

   assign start_sum = req.data.servo_id + req.data.payload_count + req.data.command_code;
   assign data_sum  = running_sum_ff + req.data.payload_byte;

   always_comb begin
      packet_open_in   = packet_open_ff;
      bytes_left_in    = bytes_left_ff;
      running_sum_in   = running_sum_ff;
      job.kind         = JOB_ERROR;
      job.id_byte      = req.data.servo_id;
      job.cnt_byte     = req.data.payload_count;
      job.cmd_dat_byte = req.data.payload_byte;
      job.chk_byte     = ~data_sum;
      job.with_chk     = 1'b0;
      if (req.data.operation == OP_START) begin
         job.kind         = JOB_START;
         job.cmd_dat_byte = req.data.command_code;
         job.chk_byte     = ~start_sum;
         job.with_chk     = (req.data.payload_count == 8'd0);
         if (accept) begin
            running_sum_in = start_sum;
            bytes_left_in  = req.data.payload_count;
            packet_open_in = (req.data.payload_count != 8'd0);
         end
      end else if (packet_open_ff) begin
         job.kind     = JOB_DATA;
         job.with_chk = (bytes_left_ff == 8'd1);
         if (accept) begin
            running_sum_in = data_sum;
            bytes_left_in  = bytes_left_ff - 8'd1;
            packet_open_in = (bytes_left_ff != 8'd1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         packet_open_ff <= 1'b0;
         bytes_left_ff  <= '0;
         running_sum_ff <= '0;
      end else begin
         packet_open_ff <= packet_open_in;
         bytes_left_ff  <= bytes_left_in;
         running_sum_ff <= running_sum_in;
      end
   end

   a_open_matches_left: assert property (@(posedge clock) disable iff (reset)
      packet_open_ff == (bytes_left_ff != 8'd0))
      else $error("open flag disagrees with byte count");

   a_error_keeps_state: assert property (@(posedge clock) disable iff (reset)
      (accept && req.data.operation == OP_DATA && !packet_open_ff)
      |=> ($stable(running_sum_ff) && $stable(bytes_left_ff)))
      else $error("stray data transfer changed packet state");

   a_start_opens: assert property (@(posedge clock) disable iff (reset)
      (accept && req.data.operation == OP_START)
      |=> (bytes_left_ff == $past(req.data.payload_count)))
      else $error("start transfer did not load byte count");

endmodule

`default_nettype wire

@@ sv/sbpf_back.sv @@
`default_nettype none

module sbpf_back (
   input  logic              clock,
   input  logic              reset,
   input  logic [7:0]        header_value,
   input  sbpf_pkg::job_type head_job,
   input  logic              job_empty,
   output logic              job_pop,
   sbpf_rsp_if.source        rsp
);
   import sbpf_pkg::*;

   seq_type seq_ff;
   seq_type seq_in;
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_data_ff;
   rsp_type item;
   logic    last;
   logic    step;

   assign step      = !job_empty && (!rsp_valid_ff || rsp.ready);
   assign job_pop   = step && last;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_data_ff;

   always_comb begin
      item.out_byte   = header_value;
      item.run_end    = 1'b0;
      item.packet_end = 1'b0;
      item.error      = 1'b0;
      last            = 1'b0;
      unique case (seq_ff)
         SEQ_FIRST: begin
            unique case (head_job.kind)
               JOB_START: begin
                  item.out_byte = header_value;
               end
               JOB_DATA: begin
                  item.out_byte = head_job.cmd_dat_byte;
                  item.run_end  = !head_job.with_chk;
                  last          = !head_job.with_chk;
               end
               default: begin
                  item.out_byte = ERROR_BYTE;
                  item.run_end  = 1'b1;
                  item.error    = 1'b1;
                  last          = 1'b1;
               end
            endcase
         end
         SEQ_HDR1: item.out_byte = header_value;
         SEQ_ID:   item.out_byte = head_job.id_byte;
         SEQ_CNT:  item.out_byte = head_job.cnt_byte;
         SEQ_CMD: begin
            item.out_byte = head_job.cmd_dat_byte;
            item.run_end  = head_job.with_chk;
            last          = !head_job.with_chk;
         end
         SEQ_CHK: begin
            item.out_byte   = head_job.chk_byte;
            item.run_end    = 1'b1;
            item.packet_end = 1'b1;
            last            = 1'b1;
         end
         default: item.out_byte = header_value;
      endcase
   end

   always_comb begin
      seq_in = seq_ff;
      if (step) begin
         if (last) begin
            seq_in = SEQ_FIRST;
         end else begin
            unique case (seq_ff)
               SEQ_FIRST: seq_in = (head_job.kind == JOB_START) ? SEQ_HDR1 : SEQ_CHK;
               SEQ_HDR1:  seq_in = SEQ_ID;
               SEQ_ID:    seq_in = SEQ_CNT;
               SEQ_CNT:   seq_in = SEQ_CMD;
               SEQ_CMD:   seq_in = SEQ_CHK;
               default:   seq_in = SEQ_FIRST;
            endcase
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      if (step) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= SEQ_FIRST;
         rsp_valid_ff <= 1'b0;
      end else begin
         seq_ff       <= seq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_data_ff <= item;
      end
   end

   a_job_held: assert property (@(posedge clock) disable iff (reset)
      (seq_ff != SEQ_FIRST) |-> !job_empty)
      else $error("sequencer mid-packet with no job at head");

   a_end_flags: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff.packet_end || rsp_data_ff.error))
      |-> rsp_data_ff.run_end)
      else $error("checksum or error transfer without run end");

   a_chk_after_cmd: assert property (@(posedge clock) disable iff (reset)
      (seq_ff == SEQ_CMD && step && !last) |=> (seq_ff == SEQ_CHK))
      else $error("checksum step skipped");

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import sbpf_pkg::*;

   localparam int CYCLE_LIMIT   = 300000;
   localparam int RANDOM_ITEMS  = 54;
   localparam int LONG_HOLD     = 200;
   localparam int HOLD_AFTER    = 40;

   logic       clock;
   logic       reset;
   logic       csr_wr_en;
   logic [7:0] csr_wr_data;

   sbpf_req_if req_ch();
   sbpf_rsp_if rsp_ch();

   servo_bus_packet_framer u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch)
   );

   // framer state as the block should hold it
   logic [7:0] header_byte;
   logic       frame_open;
   logic [7:0] frame_left;
   logic [7:0] frame_sum;

   req_type item_q[$];
   rsp_type frame_bytes_q[$];

   int total_queued;
   int total_accepted;
   int failures;
   int bytes_checked;
   int checksums_seen;
   int errors_seen;
   int header_settings;
   int cycle_count;

   logic    req_fire;
   logic    rsp_fire;
   int      send_gap;
   int      send_calm;
   int      sink_gap;
   int      sink_calm;
   int      hold_left;
   bit      long_hold_done;
   logic    drive_valid;
   req_type drive_item;
   logic    drive_ready;
   rsp_type got_byte;
   rsp_type want_byte;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic pick_gap(inout int calm, output int gap);
      int roll;
      if (calm > 0) begin
         calm--;
         gap = 0;
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 3) begin
            calm = $urandom_range(20, 60);
            gap  = 0;
         end else if (roll < 55) begin
            gap = 0;
         end else if (roll < 92) begin
            gap = $urandom_range(1, 3);
         end else begin
            gap = $urandom_range(8, 24);
         end
      end
   endtask

   task automatic push_byte(input logic [7:0] value, input logic last, input logic chk,
                            input logic err);
      rsp_type r;
      r.out_byte   = value;
      r.run_end    = last;
      r.packet_end = chk;
      r.error      = err;
      frame_bytes_q.push_back(r);
   endtask

   task automatic frame_item(input req_type it);
      logic empty;
      if (it.operation == OP_START) begin
         empty      = (it.payload_count == 8'd0);
         frame_sum  = it.servo_id + it.payload_count + it.command_code;
         frame_left = it.payload_count;
         frame_open = !empty;
         push_byte(header_byte, 1'b0, 1'b0, 1'b0);
         push_byte(header_byte, 1'b0, 1'b0, 1'b0);
         push_byte(it.servo_id, 1'b0, 1'b0, 1'b0);
         push_byte(it.payload_count, 1'b0, 1'b0, 1'b0);
         push_byte(it.command_code, empty, 1'b0, 1'b0);
         if (empty) begin
            push_byte(~frame_sum, 1'b1, 1'b1, 1'b0);
         end
      end else if (!frame_open) begin
         push_byte(ERROR_BYTE, 1'b1, 1'b0, 1'b1);
      end else begin
         frame_sum  = frame_sum + it.payload_byte;
         frame_left = frame_left - 8'd1;
         if (frame_left == 8'd0) begin
            frame_open = 1'b0;
            push_byte(it.payload_byte, 1'b0, 1'b0, 1'b0);
            push_byte(~frame_sum, 1'b1, 1'b1, 1'b0);
         end else begin
            push_byte(it.payload_byte, 1'b1, 1'b0, 1'b0);
         end
      end
   endtask

   task automatic queue_start(input logic [7:0] id, input logic [7:0] cnt,
                              input logic [7:0] cmd);
      req_type it;
      it.operation     = OP_START;
      it.servo_id      = id;
      it.payload_count = cnt;
      it.command_code  = cmd;
      it.payload_byte  = $urandom_range(0, 255);
      item_q.push_back(it);
      total_queued++;
   endtask

   task automatic queue_data(input logic [7:0] value);
      req_type it;
      it.operation     = OP_DATA;
      it.servo_id      = $urandom_range(0, 255);
      it.payload_count = $urandom_range(0, 255);
      it.command_code  = $urandom_range(0, 255);
      it.payload_byte  = value;
      item_q.push_back(it);
      total_queued++;
   endtask

   task automatic queue_random_traffic(input int n);
      int         target;
      int         roll;
      int         sent;
      logic [7:0] cnt;
      target = total_queued + n;
      while (total_queued < target) begin
         roll = $urandom_range(0, 99);
         if (roll < 80) begin
            if ($urandom_range(0, 19) == 0) begin
               cnt = $urandom_range(13, 40);
            end else begin
               cnt = $urandom_range(0, 12);
            end
            queue_start($urandom_range(0, 255), cnt, $urandom_range(0, 255));
            sent = cnt;
            if (cnt > 0 && $urandom_range(0, 9) == 0) begin
               sent = $urandom_range(0, cnt - 1);
            end
            repeat (sent) queue_data($urandom_range(0, 255));
         end else if (roll < 92) begin
            repeat ($urandom_range(1, 3)) queue_data($urandom_range(0, 255));
         end else begin
            queue_start($urandom_range(0, 255), $urandom_range(0, 255),
                        $urandom_range(0, 255));
         end
      end
   endtask

   task automatic write_header(input logic [7:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      header_byte = value;
      header_settings++;
   endtask

   task automatic wait_drained();
      while (total_accepted != total_queued || frame_bytes_q.size() != 0) begin
         @(negedge clock);
      end
      repeat (8) @(negedge clock);
   endtask

   // sender: one item per transfer, random gaps between items
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_gap = 0;
      end else if (!req_ch.valid || req_fire) begin
         drive_valid = 1'b0;
         if (send_gap > 0) begin
            send_gap--;
         end else if (item_q.size() > 0) begin
            drive_item  = item_q.pop_front();
            drive_valid = 1'b1;
            pick_gap(send_calm, send_gap);
         end
         req_ch.valid <= drive_valid;
         if (drive_valid) begin
            req_ch.data <= drive_item;
         end
      end
   end

   // receiver: random stalls plus one long hold-off once traffic is flowing
   always @(negedge clock) begin
      if (reset) begin
         drive_ready = 1'b0;
      end else begin
         if (rsp_fire) begin
            pick_gap(sink_calm, sink_gap);
         end
         if (hold_left > 0) begin
            hold_left--;
            drive_ready = 1'b0;
         end else if (!long_hold_done && total_accepted >= HOLD_AFTER) begin
            long_hold_done = 1'b1;
            hold_left      = LONG_HOLD - 1;
            drive_ready    = 1'b0;
         end else if (sink_gap > 0) begin
            sink_gap--;
            drive_ready = 1'b0;
         end else begin
            drive_ready = 1'b1;
         end
      end
      rsp_ch.ready <= drive_ready;
   end

   // sample both channels, predict on each input transfer, check each output transfer
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
      if (reset) begin
         req_fire <= 1'b0;
         rsp_fire <= 1'b0;
      end else begin
         req_fire <= req_ch.valid && req_ch.ready;
         rsp_fire <= rsp_ch.valid && rsp_ch.ready;
         if (req_ch.valid && req_ch.ready) begin
            frame_item(req_ch.data);
            total_accepted++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got_byte = rsp_ch.data;
            if (frame_bytes_q.size() == 0) begin
               $error("unexpected transfer: out_byte %02h run_end %0b packet_end %0b error %0b",
                      got_byte.out_byte, got_byte.run_end, got_byte.packet_end,
                      got_byte.error);
               failures++;
            end else begin
               want_byte = frame_bytes_q.pop_front();
               bytes_checked++;
               if (want_byte.packet_end) checksums_seen++;
               if (want_byte.error) errors_seen++;
               if (got_byte.out_byte !== want_byte.out_byte) begin
                  $error("out_byte: expected %02h, got %02h",
                         want_byte.out_byte, got_byte.out_byte);
                  failures++;
               end
               if (got_byte.run_end !== want_byte.run_end) begin
                  $error("run_end: expected %0b, got %0b", want_byte.run_end, got_byte.run_end);
                  failures++;
               end
               if (got_byte.packet_end !== want_byte.packet_end) begin
                  $error("packet_end: expected %0b, got %0b",
                         want_byte.packet_end, got_byte.packet_end);
                  failures++;
               end
               if (got_byte.error !== want_byte.error) begin
                  $error("error: expected %0b, got %0b", want_byte.error, got_byte.error);
                  failures++;
               end
            end
         end
      end
   end

   initial begin
      reset        = 1'b1;
      csr_wr_en    = 1'b0;
      csr_wr_data  = 8'h00;
      req_ch.valid = 1'b0;
      req_ch.data  = '0;
      rsp_ch.ready = 1'b0;
      header_byte  = HEADER_RESET;
      frame_open   = 1'b0;
      frame_left   = 8'd0;
      frame_sum    = 8'd0;
      header_settings = 1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // stray data, empty packets, checksum wrap, restart of an open packet
      queue_data(8'hFF);
      queue_start(8'h00, 8'h00, 8'h00);
      queue_start(8'hFF, 8'h00, 8'hFF);
      queue_start(8'hFE, 8'h02, 8'h03);
      queue_data(8'h00);
      queue_data(8'hFF);
      queue_data(8'h00);
      queue_start(8'h01, 8'h03, 8'h02);
      queue_data(8'h55);
      queue_start(8'h7F, 8'h01, 8'h80);
      queue_data(8'hAA);
      queue_start(8'hFF, 8'hFF, 8'hFF);
      queue_data(8'hFF);
      queue_data(8'h80);
      queue_data(8'h01);
      queue_start(8'hFF, 8'h01, 8'hFF);
      queue_data(8'hFF);
      queue_start(8'h5A, 8'h80, 8'hA5);
      queue_start(8'h12, 8'h01, 8'h34);
      queue_data(8'h7F);
      queue_data(8'h00);
      queue_random_traffic(RANDOM_ITEMS);
      wait_drained();

      write_header(8'h00);
      queue_random_traffic(RANDOM_ITEMS);
      wait_drained();

      write_header($urandom_range(1, 254));
      queue_random_traffic(RANDOM_ITEMS);
      wait_drained();

      write_header(8'hFF);
      queue_random_traffic(RANDOM_ITEMS);
      wait_drained();

      write_header($urandom_range(0, 255));
      queue_random_traffic(RANDOM_ITEMS);
      wait_drained();

      $display("Framed %0d items under %0d header settings, one long output stall included.",
               total_accepted, header_settings);
      $display("Checked %0d bytes: %0d checksums, %0d stray-data errors.",
               bytes_checked, checksums_seen, errors_seen);
      if (failures == 0 && frame_bytes_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
